// ----- sv/cfb_pkg.sv -----
package cfb_pkg;

	localparam logic [15:0] MAX_PAYLOAD    = 16'd1024;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CFG_END_MARKER     = 8'd0;
	localparam logic [7:0] CFG_FRAME_CAPACITY = 8'd1;

	localparam logic [7:0]  END_MARKER_RESET     = 8'd3;
	localparam logic [15:0] FRAME_CAPACITY_RESET = 16'hffff;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_REJECT = 2'd1;
	localparam logic [1:0] STATUS_STRAY  = 2'd2;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		JOB_HEADER,
		JOB_PAYLOAD,
		JOB_REJECT,
		JOB_STRAY
	} job_kind_t;

	typedef struct packed {
		job_kind_t       kind;
		logic [3:0][7:0] bytes;
		logic            tail;
		logic [7:0]      check;
	} job_t;

	typedef struct packed {
		logic [7:0]  end_marker;
		logic [15:0] frame_capacity;
	} cfg_t;

endpackage

// ----- sv/cfb_if.sv -----
interface cfb_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  start_code;
	logic [7:0]  opcode;
	logic [15:0] payload_length;
	logic [7:0]  payload_byte;

	modport source (
		output valid, command, start_code, opcode, payload_length, payload_byte,
		input  ready
	);
	modport sink (
		input  valid, command, start_code, opcode, payload_length, payload_byte,
		output ready
	);
endinterface

interface cfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic       frame_end;
	logic [1:0] status;

	modport source (
		output valid, out_byte, byte_valid, last, frame_end, status,
		input  ready
	);
	modport sink (
		input  valid, out_byte, byte_valid, last, frame_end, status,
		output ready
	);
endinterface

interface cfb_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ----- sv/checksummed_frame_builder_unit.sv -----
// Frame builder: every accepted word is classified and written into the job queue, and the
// front takes a new word each cycle while the four-entry job queue has room. A payload
// word gives one frame word (three when it closes the frame), a start word four header
// words (six for an empty payload), and a rejected start or a stray payload byte one
// status word. The output register sends one word per cycle while result.ready is high,
// so throughput is one input word per cycle for payload and bursts are absorbed by the
// job queue; an input word passes through a job queue entry and then the output register.
module checksummed_frame_builder_unit (
	input  logic   clk,
	input  logic   arst_n,
	cfb_in_if.sink     item,
	cfb_out_if.source  result,
	cfb_cfg_if.sink    cfg
);
	import cfb_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_marker     <= END_MARKER_RESET;
			cfg_q.frame_capacity <= FRAME_CAPACITY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_END_MARKER:     cfg_q.end_marker     <= cfg.data[7:0];
				CFG_FRAME_CAPACITY: cfg_q.frame_capacity <= cfg.data;
				default: ;
			endcase
		end
	end

	cfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	cfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	cfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.cfg       (cfg_q),
		.result    (result)
	);

	a_end_marker_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_end |-> result.byte_valid && result.last)
		else $error("end marker word not flagged as last frame byte");

	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.status != STATUS_OK) |-> !result.byte_valid && result.last)
		else $error("status word carries a frame byte");

	a_queue_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && !pop_ready |=> pop_valid && $stable(pop_job))
		else $error("queue head changed while the back end was working on it");

endmodule

// ----- sv/cfb_front.sv -----
module cfb_front (
	input  logic          clk,
	input  logic          arst_n,
	cfb_in_if.sink        item,
	input  cfb_pkg::cfg_t cfg,
	output logic          push_valid,
	input  logic          push_ready,
	output cfb_pkg::job_t push_job
);
	import cfb_pkg::*;

	logic [7:0]  running_sum_q;
	logic [15:0] bytes_left_q;
	logic        frame_open_q;

	logic        accept;
	logic        too_long;
	logic [15:0] len_field;
	logic [7:0]  sum_hdr;
	logic [7:0]  sum_pl;
	logic        stray;
	logic        closing;

	assign item.ready = push_ready;
	assign push_valid = item.valid;
	assign accept     = item.valid && push_ready;

	assign too_long  = (item.payload_length > MAX_PAYLOAD) ||
		(({1'b0, item.payload_length} + FRAME_OVERHEAD) > {1'b0, cfg.frame_capacity});
	assign len_field = item.payload_length + 16'd1;
	assign sum_hdr   = len_field[15:8] + len_field[7:0] + item.opcode;
	assign sum_pl    = running_sum_q + item.payload_byte;
	assign stray     = !frame_open_q || (bytes_left_q == 16'd0);
	assign closing   = (bytes_left_q == 16'd1);

	// classify the word into a job for the back end
	always_comb begin
		push_job       = '0;
		push_job.kind  = JOB_STRAY;
		if (item.command == CMD_START) begin
			if (too_long) begin
				push_job.kind = JOB_REJECT;
			end else begin
				push_job.kind     = JOB_HEADER;
				push_job.bytes[0] = item.start_code;
				push_job.bytes[1] = len_field[15:8];
				push_job.bytes[2] = len_field[7:0];
				push_job.bytes[3] = item.opcode;
				push_job.tail     = (item.payload_length == 16'd0);
				push_job.check    = 8'd0 - sum_hdr;
			end
		end else if (!stray) begin
			push_job.kind     = JOB_PAYLOAD;
			push_job.bytes[0] = item.payload_byte;
			push_job.tail     = closing;
			push_job.check    = 8'd0 - sum_pl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			bytes_left_q  <= '0;
			frame_open_q  <= 1'b0;
		end else if (accept) begin
			if (item.command == CMD_START) begin
				running_sum_q <= too_long ? 8'd0 : sum_hdr;
				bytes_left_q  <= too_long ? 16'd0 : item.payload_length;
				frame_open_q  <= !too_long && (item.payload_length != 16'd0);
			end else if (stray) begin
				frame_open_q <= 1'b0;
			end else begin
				running_sum_q <= sum_pl;
				bytes_left_q  <= bytes_left_q - 16'd1;
				if (closing) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- sv/cfb_queue.sv -----
module cfb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cfb_pkg::job_t push_job,
	output logic          pop_valid,
	input  logic          pop_ready,
	output cfb_pkg::job_t pop_job
);
	import cfb_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/cfb_back.sv -----
module cfb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  cfb_pkg::job_t pop_job,
	input  cfb_pkg::cfg_t cfg,
	cfb_out_if.source     result
);
	import cfb_pkg::*;

	logic [2:0] step_q;
	logic       res_valid_q;
	logic [7:0] res_byte_q;
	logic       res_byte_valid_q;
	logic       res_last_q;
	logic       res_frame_end_q;
	logic [1:0] res_status_q;

	logic       load;
	logic [2:0] body_n;
	logic [7:0] nxt_byte;
	logic       nxt_byte_valid;
	logic       nxt_last;
	logic       nxt_frame_end;
	logic [1:0] nxt_status;

	assign load      = !res_valid_q || result.ready;
	assign pop_ready = load && nxt_last;
	assign body_n    = (pop_job.kind == JOB_HEADER) ? 3'd4 : 3'd1;

	// one output word per step of the job at the queue head
	always_comb begin
		nxt_byte       = 8'd0;
		nxt_byte_valid = 1'b0;
		nxt_last       = 1'b1;
		nxt_frame_end  = 1'b0;
		nxt_status     = STATUS_OK;
		unique case (pop_job.kind) inside
			JOB_REJECT: begin
				nxt_status = STATUS_REJECT;
			end
			JOB_STRAY: begin
				nxt_status = STATUS_STRAY;
			end
			JOB_HEADER, JOB_PAYLOAD: begin
				nxt_byte_valid = 1'b1;
				if (step_q < body_n) begin
					nxt_byte = pop_job.bytes[step_q[1:0]];
					nxt_last = !pop_job.tail && (step_q == body_n - 3'd1);
				end else if (step_q == body_n) begin
					nxt_byte = pop_job.check;
					nxt_last = 1'b0;
				end else begin
					nxt_byte      = cfg.end_marker;
					nxt_frame_end = 1'b1;
				end
			end
			default: begin
				nxt_status = STATUS_STRAY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= pop_valid;
			if (pop_valid) begin
				step_q <= nxt_last ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			res_byte_q       <= nxt_byte;
			res_byte_valid_q <= nxt_byte_valid;
			res_last_q       <= nxt_last;
			res_frame_end_q  <= nxt_frame_end;
			res_status_q     <= nxt_status;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.out_byte   = res_byte_q;
	assign result.byte_valid = res_byte_valid_q;
	assign result.last       = res_last_q;
	assign result.frame_end  = res_frame_end_q;
	assign result.status     = res_status_q;

endmodule
